/* src/fwua_pkg.sv */
// Shared command codes and control structs for the fixed-width unsigned ALU.
package fwua_pkg;

    // Command codes carried on the request channel.
    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_SHL = 4'd2,
        CMD_SHR = 4'd3,
        CMD_MUL = 4'd4,
        CMD_DIV = 4'd5,
        CMD_MOD = 4'd6,
        CMD_GT  = 4'd7,
        CMD_GE  = 4'd8,
        CMD_EQ  = 4'd9
    } t_cmd;

    localparam int unsigned CMD_W     = 4;
    localparam int unsigned OPERAND_W = 32;

    // Start request from the controller to the multiply/divide engine.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

    // Status returned by the multiply/divide engine.
    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

/* src/fwua_if.sv */
// Valid/ready channel interfaces for ALU requests and responses.
interface fwua_req_if;
    logic                            valid;
    logic                            ready;
    logic [fwua_pkg::CMD_W-1:0]      command;
    logic [fwua_pkg::OPERAND_W-1:0]  operand_a;
    logic [fwua_pkg::OPERAND_W-1:0]  operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

interface fwua_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [fwua_pkg::OPERAND_W-1:0]  result;
    logic                            compare_true;
    logic                            divide_by_zero;

    modport source (output valid, output result, output compare_true,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input result, input compare_true,
                    input divide_by_zero, output ready);
endinterface

/* src/fixed_width_unsigned_alu.sv */
// Top level of the fixed-width unsigned ALU: sequencer, combinational ops and output register.
//
//  channel | dir | handshake           | payload
//  i_req   | in  | valid/ready         | command, operand_a, operand_b
//  o_rsp   | out | valid/ready         | result, compare_true, divide_by_zero
//
// Add, sub, shifts, compares and a zero divisor go from the operand registers via the finish
// state to the output register; mul, div and mod first wait on the one-bit-per-cycle engine.
// A new request is taken only while the sequencer is idle; it may be taken while a
// finished result still waits in the output register.
// A stalled output holds the sequencer in its finish state. Reset is synchronous, active low.
module fixed_width_unsigned_alu #(
    parameter int unsigned WIDTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    fwua_req_if.sink   i_req,
    fwua_rsp_if.source o_rsp
);
    import fwua_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MULDIV,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [WIDTH-1:0]   r_a, n_a;
    logic [WIDTH-1:0]   r_b, n_b;
    logic               r_out_valid, n_out_valid;
    logic [OPERAND_W-1:0] r_result, n_result;
    logic               r_cmp, n_cmp;
    logic               r_dz, n_dz;

    logic [WIDTH-1:0]   w_a_in;
    logic [WIDTH-1:0]   w_b_in;
    logic               w_accept;
    t_md_req            w_md_req;
    t_md_stat           w_md_stat;
    logic [WIDTH-1:0]   w_md_quot;
    logic [WIDTH-1:0]   w_md_acc;
    logic [WIDTH-1:0]   w_res;
    logic               w_cmp;
    logic               w_dz;
    logic               w_out_free;

    // Operands are taken at WIDTH bits.
    assign w_a_in   = WIDTH'(i_req.operand_a);
    assign w_b_in   = WIDTH'(i_req.operand_b);
    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Launch the engine for multiply, and for divide or modulo with a nonzero divisor.
    always_comb begin
        w_md_req.start  = 1'b0;
        w_md_req.is_div = 1'b0;
        if (w_accept) begin
            if (i_req.command == CMD_MUL) begin
                w_md_req.start = 1'b1;
            end else if ((i_req.command == CMD_DIV || i_req.command == CMD_MOD)
                         && w_b_in != '0) begin
                w_md_req.start  = 1'b1;
                w_md_req.is_div = 1'b1;
            end
        end
    end

    fwua_muldiv #(
        .WIDTH(WIDTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .i_a     (w_a_in),
        .i_b     (w_b_in),
        .o_stat  (w_md_stat),
        .o_quot  (w_md_quot),
        .o_acc   (w_md_acc)
    );

    // Result selection; the shifts rely on a shift of WIDTH or more giving zero.
    always_comb begin
        w_res = '0;
        w_cmp = 1'b0;
        w_dz  = 1'b0;
        case (r_cmd)
            CMD_ADD: w_res = r_a + r_b;
            CMD_SUB: w_res = r_a - r_b;
            CMD_SHL: w_res = r_a << r_b;
            CMD_SHR: w_res = r_a >> r_b;
            CMD_MUL: w_res = w_md_acc;
            CMD_DIV: begin
                if (r_b == '0) begin
                    w_dz = 1'b1;
                end else begin
                    w_res = w_md_quot;
                end
            end
            CMD_MOD: begin
                if (r_b == '0) begin
                    w_dz = 1'b1;
                end else begin
                    w_res = w_md_acc;
                end
            end
            CMD_GT:  w_cmp = (r_a > r_b);
            CMD_GE:  w_cmp = (r_a >= r_b);
            CMD_EQ:  w_cmp = (r_a == r_b);
            default: w_res = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Sequencer and output register.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_a         = r_a;
        n_b         = r_b;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        n_cmp       = r_cmp;
        n_dz        = r_dz;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_req.command;
                    n_a     = w_a_in;
                    n_b     = w_b_in;
                    n_state = w_md_req.start ? S_MULDIV : S_FINISH;
                end
            end
            S_MULDIV: begin
                if (w_md_stat.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_result    = OPERAND_W'(w_res);
                    n_cmp       = w_cmp;
                    n_dz        = w_dz;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_a      <= n_a;
        r_b      <= n_b;
        r_result <= n_result;
        r_cmp    <= n_cmp;
        r_dz     <= n_dz;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result         = r_result;
    assign o_rsp.compare_true   = r_cmp;
    assign o_rsp.divide_by_zero = r_dz;

    // A new request never arrives while the engine is still iterating.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_md_stat.busy)
        else $error("request accepted while the multiply/divide engine is busy");

    // The engine only reports completion while the sequencer waits for it.
    a_done_in_muldiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_stat.done |-> r_state == S_MULDIV)
        else $error("engine completion outside the multiply/divide wait state");

    // A divide-by-zero response carries a zero result and no compare flag.
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.divide_by_zero) |-> (o_rsp.result == '0 && !o_rsp.compare_true))
        else $error("divide-by-zero response with nonzero result or compare flag");

endmodule

/* src/fwua_muldiv.sv */
// Iterative multiply/divide engine built around one shared adder/subtractor.
module fwua_muldiv #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fwua_pkg::t_md_req   i_req,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output fwua_pkg::t_md_stat  o_stat,
    output logic [WIDTH-1:0]    o_quot,
    output logic [WIDTH-1:0]    o_acc
);
    import fwua_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    // Product accumulator or partial remainder.
    logic [WIDTH-1:0] r_acc, n_acc;
    // Shifted multiplicand, or dividend bits shifting out while quotient bits shift in.
    logic [WIDTH-1:0] r_x, n_x;
    // Multiplier shifting right, or the divisor.
    logic [WIDTH-1:0] r_y, n_y;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_is_div, n_is_div;

    // Shared adder operands and sum, one bit wider than the remainder plus carry.
    logic [WIDTH:0]   w_add_x;
    logic [WIDTH:0]   w_add_y;
    logic [WIDTH+1:0] w_sum;
    logic             w_carry;
    logic [WIDTH:0]   w_x_shl;

    // In divide mode the adder subtracts the divisor from the shifted remainder;
    // a carry out means the trial subtraction did not go negative.
    always_comb begin
        if (r_is_div) begin
            w_add_x = {r_acc, r_x[WIDTH-1]};
            w_add_y = ~{1'b0, r_y};
        end else begin
            w_add_x = {1'b0, r_acc};
            w_add_y = {1'b0, r_x};
        end
        w_sum   = {1'b0, w_add_x} + {1'b0, w_add_y} + {{(WIDTH+1){1'b0}}, r_is_div};
        w_carry = w_sum[WIDTH+1];
    end

    // Quotient bit in for divide, zero in for multiply.
    assign w_x_shl = {r_x, r_is_div & w_carry};

    // One step per cycle: shift-add for multiply, restoring step for divide.
    always_comb begin
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_is_div = r_is_div;
        n_done   = 1'b0;
        if (i_req.start) begin
            n_acc    = '0;
            n_x      = i_a;
            n_y      = i_b;
            n_cnt    = CNT_W'(WIDTH - 1);
            n_busy   = 1'b1;
            n_is_div = i_req.is_div;
        end else if (r_busy) begin
            if (r_is_div) begin
                n_acc = w_carry ? w_sum[WIDTH-1:0] : w_add_x[WIDTH-1:0];
            end else begin
                if (r_y[0]) begin
                    n_acc = w_sum[WIDTH-1:0];
                end
                n_y = r_y >> 1;
            end
            n_x = w_x_shl[WIDTH-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_x      <= n_x;
        r_y      <= n_y;
        r_cnt    <= n_cnt;
        r_is_div <= n_is_div;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_x;
    assign o_acc       = r_acc;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the fixed-width unsigned ALU with randomized request traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fwua_pkg::*;

    localparam int unsigned WIDTH       = 32;
    localparam int unsigned RANDOM_REQS = 1900;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES = WIDTH + 8;

    // Codes outside the defined command set; the ALU must answer them with all zeros.
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 4'd10;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 4'd15;

    typedef logic [OPERAND_W-1:0] t_word;

    typedef struct {
        logic [CMD_W-1:0] command;
        t_word            operand_a;
        t_word            operand_b;
        bit               drain;
    } t_alu_request;

    typedef struct packed {
        t_word result;
        logic  compare_true;
        logic  divide_by_zero;
    } t_alu_result;

    logic i_clk;
    logic i_rst_n;

    fwua_req_if req_ch ();
    fwua_rsp_if rsp_ch ();

    fixed_width_unsigned_alu #(
        .WIDTH (WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_alu_request pending_requests[$];
    t_alu_result  expected_results[$];

    int unsigned error_count    = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned drain_count    = 0;
    int unsigned cmd_count[16];
    int unsigned send_gap   = 0;
    int unsigned recv_stall = 0;
    int unsigned idle_cycles = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    t_alu_request next_request;

    // Computes the single result that the ALU owes for one request.
    function automatic t_alu_result predict_alu(logic [CMD_W-1:0] command, t_word a, t_word b);
        t_alu_result r;
        r = '0;
        case (command)
            CMD_ADD: r.result = a + b;
            CMD_SUB: r.result = a - b;
            CMD_SHL: r.result = (b >= WIDTH) ? '0 : (a << b);
            CMD_SHR: r.result = (b >= WIDTH) ? '0 : (a >> b);
            CMD_MUL: r.result = a * b;
            CMD_DIV: begin
                if (b == '0) r.divide_by_zero = 1'b1;
                else         r.result = a / b;
            end
            CMD_MOD: begin
                if (b == '0) r.divide_by_zero = 1'b1;
                else         r.result = a % b;
            end
            CMD_GT:  r.compare_true = (a > b);
            CMD_GE:  r.compare_true = (a >= b);
            CMD_EQ:  r.compare_true = (a == b);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Operand shapes that favor the edges: zero, all ones, single bits, small and near-max.
    function automatic t_word rand_operand();
        case ($urandom_range(0, 7))
            0:       return t_word'($urandom_range(0, 15));
            1:       return '1 - t_word'($urandom_range(0, 15));
            2:       return t_word'(1) << $urandom_range(0, WIDTH - 1);
            3:       return t_word'($urandom_range(0, 16'hffff));
            4:       return t_word'($urandom) >> $urandom_range(0, WIDTH - 1);
            default: return t_word'($urandom);
        endcase
    endfunction

    // Shift amounts mostly around the width boundary, sometimes anything at all.
    function automatic t_word rand_shift();
        if ($urandom_range(0, 7) == 0) return rand_operand();
        return t_word'($urandom_range(0, WIDTH + 3));
    endfunction

    function automatic void add_request(logic [CMD_W-1:0] command, t_word a, t_word b,
                                        bit drain = 1'b0);
        t_alu_request q;
        q.command   = command;
        q.operand_a = a;
        q.operand_b = b;
        q.drain     = drain;
        pending_requests.insert(pending_requests.size(), q);
    endfunction

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Request driver: records each accepted request, then offers the next after its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results.insert(expected_results.size(),
                    predict_alu(req_ch.command, req_ch.operand_a, req_ch.operand_b));
                accepted_count++;
                cmd_count[req_ch.command]++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_requests.size() == 0 ||
                             (pending_requests[0].drain && expected_results.size() != 0)) begin
                    // Nothing left, or holding until every outstanding result is back.
                    req_ch.valid <= 1'b0;
                end else begin
                    next_request = pending_requests.pop_front();
                    if (next_request.drain) drain_count++;
                    req_ch.command   <= next_request.command;
                    req_ch.operand_a <= next_request.operand_a;
                    req_ch.operand_b <= next_request.operand_b;
                    req_ch.valid     <= 1'b1;
                    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 3);
                end
            end
        end
    end

    // Result monitor: checks each accepted result and then stalls for a random count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                checked_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result %h compare_true %b divide_by_zero %b",
                           rsp_ch.result, rsp_ch.compare_true, rsp_ch.divide_by_zero);
                    error_count++;
                end else begin
                    t_alu_result exp_r;
                    exp_r = expected_results.pop_front();
                    if (rsp_ch.result !== exp_r.result) begin
                        $error("result mismatch: expected %h, actual %h",
                               exp_r.result, rsp_ch.result);
                        error_count++;
                    end
                    if (rsp_ch.compare_true !== exp_r.compare_true) begin
                        $error("compare_true mismatch: expected %b, actual %b",
                               exp_r.compare_true, rsp_ch.compare_true);
                        error_count++;
                    end
                    if (rsp_ch.divide_by_zero !== exp_r.divide_by_zero) begin
                        $error("divide_by_zero mismatch: expected %b, actual %b",
                               exp_r.divide_by_zero, rsp_ch.divide_by_zero);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
                rsp_ch.ready <= (recv_stall == 0);
            end else if (recv_stall > 0) begin
                recv_stall--;
                rsp_ch.ready <= (recv_stall == 0);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [CMD_W-1:0] command;
        t_word            a;
        t_word            b;

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.command   = '0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        rsp_ch.ready     = 1'b0;
        foreach (cmd_count[k]) cmd_count[k] = 0;

        // Directed corners: wraparound, shift limits, division edges, compare ties.
        add_request(CMD_ADD, '1, '1);
        add_request(CMD_ADD, '0, '0);
        add_request(CMD_SUB, '0, 32'd1);
        add_request(CMD_SUB, '1, '1);
        add_request(CMD_SHL, '1, 32'd31);
        add_request(CMD_SHL, '1, 32'd32);
        add_request(CMD_SHL, 32'h8000_0001, '1);
        add_request(CMD_SHR, '1, '0);
        add_request(CMD_SHR, '1, 32'd31);
        add_request(CMD_SHR, '1, 32'd32);
        add_request(CMD_MUL, '1, '1);
        add_request(CMD_MUL, '1, '0);
        add_request(CMD_DIV, 32'd5, 32'd9);
        add_request(CMD_DIV, '1, '0);
        add_request(CMD_DIV, '1, 32'd1);
        add_request(CMD_MOD, 32'd5, 32'd9);
        add_request(CMD_MOD, 32'd12, '0);
        add_request(CMD_MOD, '1, 32'd7);
        add_request(CMD_GT,  '1, '1);
        add_request(CMD_GT,  '1, '0);
        add_request(CMD_GE,  32'd3, 32'd3);
        add_request(CMD_GE,  '0, '1);
        add_request(CMD_EQ,  '1, '1);
        add_request(CMD_EQ,  32'd1, '0);
        add_request(CMD_RSVD_FIRST, '1, '1);
        add_request(CMD_RSVD_LAST, 32'h1234_5678, '0);

        // Random requests with edge-biased operands; a few hold off until the ALU drains.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if ($urandom_range(0, 99) < 2)
                command = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
            else
                command = CMD_W'($urandom_range(CMD_ADD, CMD_EQ));
            a = rand_operand();
            case (command)
                CMD_SHL, CMD_SHR: b = rand_shift();
                CMD_DIV, CMD_MOD: b = ($urandom_range(0, 15) == 0) ? '0 : rand_operand();
                CMD_GT, CMD_GE, CMD_EQ: b = ($urandom_range(0, 2) == 0) ? a : rand_operand();
                default: b = rand_operand();
            endcase
            add_request(command, a, b, (i == RANDOM_REQS / 2) || ($urandom_range(0, 149) == 0));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d after a full drain), %0d results checked.",
                 accepted_count, drain_count, checked_count);
        $display("Mix: add %0d sub %0d shl %0d shr %0d mul %0d div %0d mod %0d gt %0d ge %0d eq %0d",
                 cmd_count[CMD_ADD], cmd_count[CMD_SUB], cmd_count[CMD_SHL],
                 cmd_count[CMD_SHR], cmd_count[CMD_MUL], cmd_count[CMD_DIV],
                 cmd_count[CMD_MOD], cmd_count[CMD_GT], cmd_count[CMD_GE], cmd_count[CMD_EQ]);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (expected_results.size() != 0) begin
                $error("%0d expected results never arrived", expected_results.size());
            end
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
